[sv/spq_pkg.sv]
`timescale 1ns / 1ps

package spq_pkg;

  localparam int CAPACITY = 8;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    op_t                     operation;
    logic signed [VAL_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] result_value;
    status_t                 status;
  } out_beat_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                    enq;
    logic                    deq;
    logic signed [VAL_W-1:0] value;
  } cell_cmd_t;

  // Per-slot occupancy derived from the count.
  typedef struct packed {
    logic used;
    logic tail;
  } cell_slot_t;

endpackage

[sv/spq_cell.sv]
`timescale 1ns / 1ps

module spq_cell (
  input  logic                             clk,
  input  spq_pkg::cell_cmd_t               cmd,
  input  spq_pkg::cell_slot_t              slot,
  input  logic signed [spq_pkg::VAL_W-1:0] left_val,
  input  logic                             left_gt,
  input  logic signed [spq_pkg::VAL_W-1:0] right_val,
  output logic signed [spq_pkg::VAL_W-1:0] val,
  output logic                             gt
);

  logic signed [spq_pkg::VAL_W-1:0] val_r;
  logic signed [spq_pkg::VAL_W-1:0] val_nxt;

  // Stored value strictly greater than the incoming one: this slot moves up.
  assign gt  = slot.used && (val_r > cmd.value);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (cmd.enq) begin
      if (left_gt) begin
        val_nxt = left_val;
      end else if (gt || slot.tail) begin
        val_nxt = cmd.value;
      end
    end else if (cmd.deq) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

[sv/sorted_min_priority_queue.sv]
`timescale 1ns / 1ps
// Sorted min-priority queue, CAPACITY signed 32-bit entries held in a chain
// of cells, smallest at cell 0.
// Input channel (in_valid / in_stall / in_beat): one beat per operation,
//   operation enqueue places value after every stored value not greater than
//   it; dequeue pops the smallest.
// Output channel (out_valid / out_stall / out_beat): exactly one beat per
//   accepted input beat, in order. status is ok, full (enqueue dropped) or
//   empty (dequeue with nothing stored); result_value is the popped value on
//   a good dequeue and 0 otherwise.
// The result enters the output register in the cycle after the input beat
//   is accepted. Throughput: one operation per cycle unless stalled; every
//   cell compares against the broadcast value and shifts in the same cycle.
// Stall: while the output register holds a beat the receiver stalls,
//   in_stall is raised and no new operation is taken.
// Reset (rst_n low, synchronous): count and output valid clear; entries are
//   not cleared since no slot at or above count is ever read.

module sorted_min_priority_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  spq_pkg::in_beat_t in_beat,
  output logic              out_valid,
  input  logic              out_stall,
  output spq_pkg::out_beat_t out_beat
);

  localparam int N = spq_pkg::CAPACITY;

  logic [spq_pkg::CNT_W-1:0] count_r;
  logic [spq_pkg::CNT_W-1:0] count_nxt;
  logic                      out_valid_r;
  spq_pkg::out_beat_t        out_beat_r;
  spq_pkg::out_beat_t        out_beat_nxt;

  logic                      in_acc;
  logic                      is_full;
  logic                      is_empty;
  spq_pkg::cell_cmd_t        cmd;

  logic signed [spq_pkg::VAL_W-1:0] cell_val [N];
  logic                             cell_gt  [N];

  // Output register frees when empty or when its beat is taken.
  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  assign is_full  = (count_r == spq_pkg::CNT_W'(N));
  assign is_empty = (count_r == '0);

  assign cmd.enq   = in_acc && (in_beat.operation == spq_pkg::OP_ENQ) && !is_full;
  assign cmd.deq   = in_acc && (in_beat.operation == spq_pkg::OP_DEQ) && !is_empty;
  assign cmd.value = in_beat.value;

  // Cell chain
  for (genvar i = 0; i < N; i++) begin : g_cell
    localparam logic [spq_pkg::CNT_W-1:0] IDX = spq_pkg::CNT_W'(i);
    spq_pkg::cell_slot_t              slot;
    logic signed [spq_pkg::VAL_W-1:0] lv;
    logic                             lg;
    logic signed [spq_pkg::VAL_W-1:0] rv;

    assign slot.used = (IDX < count_r);
    assign slot.tail = (IDX == count_r);

    if (i == 0) begin : g_head
      assign lv = cell_val[0];
      assign lg = 1'b0;
    end else begin : g_mid
      assign lv = cell_val[i-1];
      assign lg = cell_gt[i-1];
    end

    // Last cell takes its own value on a pop; that slot falls out of use.
    if (i == N - 1) begin : g_last
      assign rv = cell_val[i];
    end else begin : g_inner
      assign rv = cell_val[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .slot      (slot),
      .left_val  (lv),
      .left_gt   (lg),
      .right_val (rv),
      .val       (cell_val[i]),
      .gt        (cell_gt[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.enq) begin
      count_nxt = count_r + spq_pkg::CNT_W'(1);
    end else if (cmd.deq) begin
      count_nxt = count_r - spq_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    out_beat_nxt.result_value = '0;
    out_beat_nxt.status       = spq_pkg::ST_OK;
    if (in_beat.operation == spq_pkg::OP_ENQ) begin
      if (is_full) begin
        out_beat_nxt.status = spq_pkg::ST_FULL;
      end
    end else if (is_empty) begin
      out_beat_nxt.status = spq_pkg::ST_EMPTY;
    end else begin
      out_beat_nxt.result_value = cell_val[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_beat_r <= out_beat_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= spq_pkg::CNT_W'(N))
    else $error("count above capacity");

  a_empty_pop : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_beat.operation == spq_pkg::OP_DEQ) && is_empty)
    |=> (out_valid && (out_beat.status == spq_pkg::ST_EMPTY) && (count_r == '0)))
    else $error("pop on empty queue not reported");

  a_push_count : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_beat.operation == spq_pkg::OP_ENQ) && !is_full)
    |=> (count_r == $past(count_r) + spq_pkg::CNT_W'(1)))
    else $error("push did not bump count");

  a_full_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_beat.operation == spq_pkg::OP_ENQ) && is_full)
    |=> ((out_beat.status == spq_pkg::ST_FULL) && $stable(count_r)))
    else $error("push on full queue changed state");
`endif

endmodule
